### hw/rtl/uac_pkg.sv
// Shared constants and controller/datapath interface types for the unique address counter.
// No dependencies; imported by every module of the block.
package uac_pkg;

  localparam int CAPACITY  = 128;
  localparam int ADDR_W    = 48;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 8;

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic post;
    logic insert;
    logic drop;
    logic clear;
  } uac_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic rd_vld;
    logic full;
    logic out_free;
  } uac_sts_t;

endpackage

### hw/rtl/unique_address_counter_unit.sv
// Top level of the unique address counter: joins uac_ctrl and uac_datapath.
// Depends on uac_pkg, uac_ctrl and uac_datapath.
//
// Counts distinct 48-bit addresses in a table of CAPACITY (128) entries. An observe word
// is compared against each stored entry, one entry per clock from a single read port of
// the table memory, and the scan ends early on a match; a clear word skips the scan. A
// result still stalled in the output register holds the next item in its final cycle. The
// block takes one word at a time and holds in_stall until the result has been loaded into
// the output register; a result waiting there does not block the next input word. No
// clearing pass is needed after reset.
module unique_address_counter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  uac_pkg::addr_t    in_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_new,
  output logic              out_dropped_full,
  output uac_pkg::out_cnt_t out_unique_count
);
  import uac_pkg::*;

  uac_cmd_t cmd;
  uac_sts_t sts;

  uac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  uac_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_address       (in_address),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_new       (out_is_new),
    .out_dropped_full (out_dropped_full),
    .out_unique_count (out_unique_count)
  );

endmodule

### hw/rtl/uac_datapath.sv
// Datapath: address table memory, scan index, compare, count and output word register.
// Depends on uac_pkg; driven by uac_ctrl through uac_cmd_t.
module uac_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  uac_pkg::addr_t    in_address,
  input  uac_pkg::uac_cmd_t cmd,
  output uac_pkg::uac_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_new,
  output logic              out_dropped_full,
  output uac_pkg::out_cnt_t out_unique_count
);
  import uac_pkg::*;

  addr_t mem [CAPACITY];

  addr_t    addr_r;
  addr_t    rd_data_r;
  logic     rd_vld_r;
  cnt_t     rd_idx_r;
  cnt_t     count_r;
  cnt_t     count_nxt;
  logic     out_valid_r;
  logic     is_new_r;
  logic     dropped_r;
  out_cnt_t out_count_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_address;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
    if (cmd.post && cmd.insert) begin
      mem[count_r[IDX_W-1:0]] <= addr_r;
    end
    if (cmd.post) begin
      is_new_r    <= cmd.insert;
      dropped_r   <= cmd.drop;
      out_count_r <= OUT_CNT_W'(count_nxt);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.insert) begin
      count_nxt = count_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.load) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_en) begin
        rd_idx_r <= rd_idx_r + cnt_t'(1);
      end
      if (cmd.post) begin
        count_r <= count_nxt;
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.hit      = rd_vld_r && (rd_data_r == addr_r);
  assign sts.scan_end = (rd_idx_r == count_r);
  assign sts.rd_vld   = rd_vld_r;
  assign sts.full     = (count_r == cnt_t'(CAPACITY));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_is_new       = is_new_r;
  assign out_dropped_full = dropped_r;
  assign out_unique_count = out_count_r;

endmodule

### hw/rtl/uac_ctrl.sv
// Controller state machine: accepts a word, sequences the table scan, then posts the result.
// Depends on uac_pkg; commands uac_datapath through uac_cmd_t.
module uac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  uac_pkg::uac_sts_t sts,
  output uac_pkg::uac_cmd_t cmd
);
  import uac_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       kind_r, kind_nxt;
  logic       found_r, found_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    found_nxt  = found_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          kind_nxt  = in_kind;
          found_nxt = 1'b0;
          state_nxt = (in_kind == KIND_CLEAR) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = !sts.scan_end && !sts.hit;
        priority if (sts.hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else if (sts.scan_end && !sts.rd_vld) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.post   = 1'b1;
          cmd.clear  = (kind_r == KIND_CLEAR);
          cmd.insert = (kind_r == KIND_OBSERVE) && !found_r && !sts.full;
          cmd.drop   = (kind_r == KIND_OBSERVE) && !found_r && sts.full;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_OBSERVE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

### dv/tb.sv
// Testbench for unique_address_counter_unit: directed and random observe/clear words
// checked against a shadow address table. Depends on uac_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
  import uac_pkg::*;

  typedef struct packed {
    logic     is_new;
    logic     dropped_full;
    out_cnt_t unique_count;
  } tally_t;

  typedef struct {
    logic  kind;
    addr_t address;
    int    gap;
    bit    drain;
  } obs_word_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     in_kind = KIND_OBSERVE;
  addr_t    in_address = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  logic     out_is_new;
  logic     out_dropped_full;
  out_cnt_t out_unique_count;

  obs_word_t stim_q[$];
  tally_t    tally_q[$];
  addr_t     shadow_table[CAPACITY];
  int        shadow_count = 0;
  int        mismatches = 0;
  bit        in_fire = 1'b0;
  bit        out_fire = 1'b0;
  int        in_wait = 0;
  int        out_wait = 0;
  int        run_left[2] = '{0, 0};
  bit        calm_run[2] = '{1'b0, 1'b0};

  unique_address_counter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_new       (out_is_new),
    .out_dropped_full (out_dropped_full),
    .out_unique_count (out_unique_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // side 0 paces the input words, side 1 the result stalls
  function automatic int pick_wait(int side);
    if (run_left[side] == 0) begin
      run_left[side] = $urandom_range(8, 40);
      calm_run[side] = ($urandom_range(0, 2) == 0);
    end
    run_left[side]--;
    return calm_run[side] ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic addr_t rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic tally_t predict_tally(logic kind, addr_t address);
    tally_t t;
    bit     hit;
    t = '0;
    hit = 1'b0;
    if (kind == KIND_CLEAR) begin
      shadow_count = 0;
    end else begin
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_table[i] == address) hit = 1'b1;
      end
      if (!hit) begin
        if (shadow_count < CAPACITY) begin
          shadow_table[shadow_count] = address;
          shadow_count++;
          t.is_new = 1'b1;
        end else begin
          t.dropped_full = 1'b1;
        end
      end
    end
    t.unique_count = out_cnt_t'(shadow_count);
    return t;
  endfunction

  task automatic push_word(logic kind, addr_t address, bit drain);
    obs_word_t w;
    w.kind = kind;
    w.address = address;
    w.gap = pick_wait(0);
    w.drain = drain;
    stim_q.push_back(w);
  endtask

  always @(posedge clk) begin
    tally_t want;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (out_fire) begin
      if (tally_q.size() == 0) begin
        $error("result with no word outstanding: is_new %0d dropped_full %0d count %0d",
               out_is_new, out_dropped_full, out_unique_count);
        mismatches++;
      end else begin
        want = tally_q.pop_front();
        if (out_is_new !== want.is_new) begin
          $error("is_new expected %0d got %0d", want.is_new, out_is_new);
          mismatches++;
        end
        if (out_dropped_full !== want.dropped_full) begin
          $error("dropped_full expected %0d got %0d", want.dropped_full, out_dropped_full);
          mismatches++;
        end
        if (out_unique_count !== want.unique_count) begin
          $error("unique_count expected %0d got %0d", want.unique_count, out_unique_count);
          mismatches++;
        end
      end
    end
    if (in_fire) tally_q.push_back(predict_tally(in_kind, in_address));
  end

  always @(negedge clk) begin
    obs_word_t w;
    logic      next_valid;
    if (rst_n && !(in_valid && !in_fire)) begin
      next_valid = 1'b0;
      if (stim_q.size() > 0) begin
        if (in_wait < stim_q[0].gap) begin
          in_wait++;
        end else if (!(stim_q[0].drain && tally_q.size() > 0)) begin
          w = stim_q.pop_front();
          in_kind <= w.kind;
          in_address <= w.address;
          next_valid = 1'b1;
          in_wait = 0;
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(negedge clk) begin
    if (out_fire) out_wait = pick_wait(1);
    if (rst_n && out_wait > 0) begin
      out_stall <= 1'b1;
      if (out_valid) out_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    addr_t base;
    addr_t pool[$];
    int    n_pool;
    int    n_obs;
    int    r;
    bit    wide;

    push_word(KIND_OBSERVE, 48'h0000_0000_0000, 1'b0);
    push_word(KIND_OBSERVE, 48'hFFFF_FFFF_FFFF, 1'b0);
    push_word(KIND_OBSERVE, 48'h0000_0000_0000, 1'b0);
    push_word(KIND_OBSERVE, 48'hFFFF_FFFF_FFFF, 1'b0);
    push_word(KIND_OBSERVE, 48'h8000_0000_0000, 1'b0);
    push_word(KIND_OBSERVE, 48'h0000_0000_0001, 1'b0);
    push_word(KIND_OBSERVE, 48'hAAAA_AAAA_AAAA, 1'b0);
    push_word(KIND_OBSERVE, 48'h5555_5555_5555, 1'b0);
    push_word(KIND_OBSERVE, 48'h7FFF_FFFF_FFFF, 1'b0);
    push_word(KIND_OBSERVE, 48'hFFFF_FFFF_FFFE, 1'b0);
    push_word(KIND_OBSERVE, 48'h8000_0000_0000, 1'b0);
    push_word(KIND_CLEAR, 48'hFFFF_FFFF_FFFF, 1'b0);
    push_word(KIND_OBSERVE, 48'hFFFF_FFFF_FFFF, 1'b1);
    push_word(KIND_CLEAR, 48'h0000_0000_0000, 1'b0);
    push_word(KIND_CLEAR, 48'h0000_0000_0000, 1'b0);
    push_word(KIND_OBSERVE, 48'h0000_0000_0001, 1'b0);

    // fill the table, then hit it with new and repeated addresses
    base = rand_addr();
    push_word(KIND_CLEAR, rand_addr(), 1'b1);
    for (int i = 0; i < CAPACITY; i++) push_word(KIND_OBSERVE, {base[47:8], 8'(i)}, 1'b0);
    push_word(KIND_OBSERVE, {base[47:8] ^ 40'h1, 8'h00}, 1'b0);
    push_word(KIND_OBSERVE, {base[47:8], 8'd77}, 1'b0);
    push_word(KIND_OBSERVE, rand_addr(), 1'b0);
    push_word(KIND_OBSERVE, {base[47:8], 8'd127}, 1'b0);

    while (stim_q.size() < 1700) begin
      wide = ($urandom_range(0, 3) == 0);
      n_pool = wide ? $urandom_range(120, 170) : $urandom_range(3, 40);
      n_obs = wide ? 2 * n_pool : n_pool * $urandom_range(1, 3);
      base = rand_addr();
      pool.delete();
      for (int i = 0; i < n_pool; i++) begin
        pool.push_back($urandom_range(0, 1) ? base ^ (48'd1 << $urandom_range(0, 47))
                                            : rand_addr());
      end
      push_word(KIND_CLEAR, rand_addr(), $urandom_range(0, 4) == 0);
      for (int j = 0; j < n_obs; j++) begin
        r = $urandom_range(0, 19);
        if (r == 0 && !wide) push_word(KIND_CLEAR, rand_addr(), 1'b0);
        else if (r == 1) push_word(KIND_OBSERVE, rand_addr(), 1'b0);
        else push_word(KIND_OBSERVE, pool[$urandom_range(0, n_pool - 1)], 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (stim_q.size() == 0 && !in_valid);
    wait (tally_q.size() == 0);
    repeat (140) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
